/* src/locc_pkg.sv */
// ----------------------------------------------------------------------------
// locc_pkg: shared types and constants of the lock order cycle checker
// Status codes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package locc_pkg;

	// default sizes
	localparam int unsigned NUM_LOCKS_DEF  = 32;
	localparam int unsigned HOLD_DEPTH_DEF = 16;

	// fixed field widths
	localparam int unsigned LOCK_ID_W = 5;
	localparam int unsigned STATUS_W  = 3;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DEADLOCK = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOT_TOP  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_TOP,
		S_ROW,
		S_PICK,
		S_EXPAND,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_in;   // latch the accepted request
		logic    rd_pick;   // row read at the picked search node, else at the top lock
		logic    row_wr;    // record the edge top -> id
		logic    dfs_init;  // start the reachability search at id
		logic    dfs_pick;  // take the lowest pending node out of the work set
		logic    dfs_step;  // merge the row just read into the search
		logic    finish;    // deliver the result and update stack and halt
		logic    push;
		logic    pop;
		status_t res_status;
		logic    res_edge;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic halted;
		logic cmd_rel;
		logic full;
		logic empty;
		logic top_eq;
		logic edge_exists;
		logic hit;
		logic pending_empty;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* src/locc_ctrl.sv */
// ----------------------------------------------------------------------------
// locc_ctrl: sequencer of the lock order cycle checker
// Walks each request through stack check, edge lookup, edge insertion and the
// reachability search, and holds the result code until it is delivered.
// ----------------------------------------------------------------------------
module locc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  locc_pkg::ctrl_sts_t    sts,
	output locc_pkg::ctrl_cmd_t    cmd
);
	import locc_pkg::*;

	state_t  state_q, state_d;
	status_t res_status_q, res_status_d;
	logic    res_edge_q, res_edge_d;
	logic    res_push_q, res_push_d;
	logic    res_pop_q, res_pop_d;

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
			res_edge_q   <= 1'b0;
			res_push_q   <= 1'b0;
			res_pop_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_edge_q   <= res_edge_d;
			res_push_q   <= res_push_d;
			res_pop_q    <= res_pop_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_edge_d   = res_edge_q;
		res_push_d   = res_push_q;
		res_pop_d    = res_pop_q;
		cmd          = '0;
		cmd.res_status = res_status_q;
		cmd.res_edge   = res_edge_q;
		cmd.push       = res_push_q;
		cmd.pop        = res_pop_q;
		in_stall     = (state_q != S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				res_status_d = ST_OK;
				res_edge_d   = 1'b0;
				res_push_d   = 1'b0;
				res_pop_d    = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					// a halted block ignores the request
					state_d = sts.halted ? S_DONE : S_TOP;
				end
			end
			S_TOP: begin
				state_d = S_DONE;
				if (sts.cmd_rel) begin
					if (sts.empty) begin
						res_status_d = ST_EMPTY;
					end else if (!sts.top_eq) begin
						res_status_d = ST_NOT_TOP;
					end else begin
						res_pop_d = 1'b1;
					end
				end else if (sts.full) begin
					res_status_d = ST_OVERFLOW;
				end else if (sts.empty || sts.top_eq) begin
					res_push_d = 1'b1;
				end else begin
					// row of the top lock is being read
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				if (sts.edge_exists) begin
					res_push_d = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.row_wr   = 1'b1;
					cmd.dfs_init = 1'b1;
					res_edge_d   = 1'b1;
					state_d      = S_PICK;
				end
			end
			S_PICK: begin
				if (sts.pending_empty) begin
					res_push_d = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.rd_pick  = 1'b1;
					cmd.dfs_pick = 1'b1;
					state_d      = S_EXPAND;
				end
			end
			S_EXPAND: begin
				if (sts.hit) begin
					// the new lock reaches the top lock: cycle closed
					res_status_d = ST_DEADLOCK;
					res_push_d   = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.dfs_step = 1'b1;
					state_d      = S_PICK;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* src/locc_datapath.sv */
// ----------------------------------------------------------------------------
// locc_datapath: storage and search logic of the lock order cycle checker
// Holds the held-lock stack, the lock order matrix with row valid bits, the
// search sets and the output register.
// ----------------------------------------------------------------------------
module locc_datapath #(
	parameter int unsigned NUM_LOCKS  = locc_pkg::NUM_LOCKS_DEF,
	parameter int unsigned HOLD_DEPTH = locc_pkg::HOLD_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_in,
	input  logic [locc_pkg::LOCK_ID_W-1:0]   lock_id_in,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [locc_pkg::STATUS_W-1:0]    status,
	output logic                             edge_added,
	output logic                             halted,
	input  locc_pkg::ctrl_cmd_t              cmd,
	output locc_pkg::ctrl_sts_t              sts
);
	import locc_pkg::*;

	localparam int unsigned IDW     = $clog2(NUM_LOCKS);
	localparam int unsigned SW      = $clog2(HOLD_DEPTH);
	localparam int unsigned CW      = $clog2(HOLD_DEPTH + 1);
	localparam int unsigned ID_SPAN = 2 ** LOCK_ID_W;

	// lock id folding table, worked out at elaboration
	logic [IDW-1:0] mod_tab [ID_SPAN];
	for (genvar g = 0; g < ID_SPAN; g++) begin : g_mod
		localparam int unsigned Rem = g % NUM_LOCKS;
		assign mod_tab[g] = IDW'(Rem);
	end

	// request registers
	logic           cmd_q;
	logic [IDW-1:0] id_q;
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= cmd_in;
			id_q  <= mod_tab[lock_id_in];
		end
	end

	// held-lock stack
	logic [IDW-1:0] stack_mem [HOLD_DEPTH];
	logic [IDW-1:0] top_q;
	logic [CW-1:0]  count_q;
	logic [SW-1:0]  top_addr;
	logic [SW-1:0]  push_addr;
	logic           do_push, do_pop;

	assign top_addr  = SW'(count_q - CW'(1));
	assign push_addr = count_q[SW-1:0];
	assign do_push   = cmd.finish && cmd.push;
	assign do_pop    = cmd.finish && cmd.pop;

	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[push_addr] <= id_q;
		end
		top_q <= stack_mem[top_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + CW'(1);
		end else if (do_pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	// lock order matrix, rows read as zero until written
	logic [NUM_LOCKS-1:0] row_mem [NUM_LOCKS];
	logic [NUM_LOCKS-1:0] row_valid_q;
	logic [NUM_LOCKS-1:0] row_rd_q;
	logic                 row_rd_vld_q;
	logic [NUM_LOCKS-1:0] row_data;
	logic [NUM_LOCKS-1:0] id_bit;
	logic [IDW-1:0]       pick_id;
	logic [IDW-1:0]       rd_addr;

	assign row_data = row_rd_vld_q ? row_rd_q : '0;
	assign id_bit   = NUM_LOCKS'(1) << id_q;
	assign rd_addr  = cmd.rd_pick ? pick_id : top_q;

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			row_mem[top_q] <= row_data | id_bit;
		end
		row_rd_q     <= row_mem[rd_addr];
		row_rd_vld_q <= row_valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.row_wr) begin
			row_valid_q[top_q] <= 1'b1;
		end
	end

	// lowest pending search node
	function automatic logic [IDW-1:0] first_set(input logic [NUM_LOCKS-1:0] v);
		logic [IDW-1:0] r;
		r = '0;
		for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
			if (v[i]) r = IDW'(i);
		end
		return r;
	endfunction

	// reachability search sets
	logic [NUM_LOCKS-1:0] reach_q;
	logic [NUM_LOCKS-1:0] pending_q;
	logic [NUM_LOCKS-1:0] fresh;

	assign pick_id = first_set(pending_q);
	assign fresh   = row_data & ~reach_q;

	always_ff @(posedge clk) begin
		if (cmd.dfs_init) begin
			reach_q   <= id_bit;
			pending_q <= id_bit;
		end else if (cmd.dfs_pick) begin
			pending_q[pick_id] <= 1'b0;
		end else if (cmd.dfs_step) begin
			reach_q   <= reach_q | fresh;
			pending_q <= pending_q | fresh;
		end
	end

	// sticky halt and output register
	logic                fault_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                edge_q;
	logic                halted_q;
	logic                res_fault;

	assign res_fault = (cmd.res_status != ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && res_fault) begin
				fault_q <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.res_status;
			edge_q   <= cmd.res_edge;
			halted_q <= fault_q || res_fault;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign edge_added = edge_q;
	assign halted     = halted_q;

	// status toward the controller
	always_comb begin
		sts               = '0;
		sts.halted        = fault_q;
		sts.cmd_rel       = cmd_q;
		sts.full          = (count_q == CW'(HOLD_DEPTH));
		sts.empty         = (count_q == '0);
		sts.top_eq        = (top_q == id_q);
		sts.edge_exists   = row_data[id_q];
		sts.hit           = row_data[top_q];
		sts.pending_empty = (pending_q == '0);
		sts.out_free      = !out_valid_q || !out_stall;
	end

endmodule

/* src/lock_order_cycle_checker.sv */
// ----------------------------------------------------------------------------
// lock_order_cycle_checker: lock order graph deadlock detection, one thread
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each request acquires (cmd 0) or releases (cmd 1) a lock and yields one
// result. A release, a repeated acquire of the top lock, an acquire on an
// empty stack or a stack fault is settled by the stack check alone. An
// acquire of an already known order also takes the matrix row lookup, and
// any request once halted goes straight to the result. An acquire that
// adds a new order edge runs a reachability search from the new lock, one
// matrix row read per lock reached, each through a pick and an expand step.
// One request is in work at a time. The next one can be taken as soon as
// the result is loaded, even while that result still waits in the output
// register. Matrix rows read as empty after reset through per-row valid
// bits, so no clearing pass is needed.
module lock_order_cycle_checker #(
	parameter int unsigned NUM_LOCKS  = locc_pkg::NUM_LOCKS_DEF,
	parameter int unsigned HOLD_DEPTH = locc_pkg::HOLD_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [locc_pkg::LOCK_ID_W-1:0] lock_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [locc_pkg::STATUS_W-1:0]  status,
	output logic                           edge_added,
	output logic                           halted
);
	import locc_pkg::*;

	ctrl_cmd_t ctl_cmd;
	ctrl_sts_t ctl_sts;

	// sequencer
	locc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	// storage and search
	locc_datapath #(
		.NUM_LOCKS  (NUM_LOCKS),
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_in     (cmd),
		.lock_id_in (lock_id),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.edge_added (edge_added),
		.halted     (halted),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts)
	);

endmodule

/* src/locc_checker.sv */
// ----------------------------------------------------------------------------
// locc_checker: port level checks of the lock order cycle checker
// Relations between result fields and the sticky halt over time.
// ----------------------------------------------------------------------------
module locc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [locc_pkg::STATUS_W-1:0]  status,
	input logic                           edge_added,
	input logic                           halted
);
	import locc_pkg::*;

	// a result showing halt is directly followed only by no result or a halted one
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |=> !out_valid || halted)
		else $error("halt dropped after a fault");

	// a fault result always comes with halt
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> halted)
		else $error("fault reported without halt");

	// a new edge only appears with ok or deadlock
	a_edge_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_added |-> (status == ST_OK) || (status == ST_DEADLOCK))
		else $error("edge reported with a stack fault");

	// a deadlock is only found right after a new edge
	a_deadlock_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DEADLOCK) |-> edge_added)
		else $error("deadlock without a new edge");

	// a stalled result holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(edge_added)
			&& $stable(halted))
		else $error("stalled result changed");

endmodule

bind lock_order_cycle_checker locc_checker u_locc_checker (.*);
